[rtl/ssgt_pkg.sv]
// Package for the source sequence gap table: sizes, request and chain link types, FSM states.
`default_nettype none
package ssgt_pkg;

  localparam int unsigned PeerCount = 8;
  localparam int unsigned IdxW      = (PeerCount > 1) ? $clog2(PeerCount) : 1;
  localparam int unsigned MacW      = 48;
  localparam int unsigned SeqW      = 32;
  localparam int unsigned PeerIdxW  = 3;

  typedef struct packed {
    logic [MacW-1:0] mac;
    logic [SeqW-1:0] seq;
    logic            track;
  } req_t;

  // Passed from cell to cell; cell 0 sees all zero.
  typedef struct packed {
    logic            hit_seen;   // some cell so far matched the address
    logic            free_seen;  // some cell so far is free
    logic            sel;        // some cell so far serves the transaction
    logic [IdxW-1:0] idx;        // index of the serving cell
    logic            gap;        // gap flag of the serving cell
  } link_t;

  // Per-cycle commands from the sequencer to every cell.
  typedef struct packed {
    logic match_en;
    logic upd_en;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } state_e;

endpackage
`default_nettype wire

[rtl/ssgt_cell.sv]
// One table entry: address compare, claim and sequence check, chained to its neighbours.
`default_nettype none
module ssgt_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ssgt_pkg::cell_ctrl_t ctrl_i,
  input  wire ssgt_pkg::req_t     req_i,
  input  wire logic [ssgt_pkg::IdxW-1:0] cell_id_i,
  input  wire logic               any_hit_i,
  input  wire ssgt_pkg::link_t    link_i,
  output ssgt_pkg::link_t         link_o
);
  import ssgt_pkg::*;

  logic            valid_q, valid_d;
  logic            has_q, has_d;
  logic [SeqW-1:0] last_q, last_d;
  logic [MacW-1:0] addr_q;
  logic            match_q, match_d;

  logic            claim_here;
  logic            sel_here;
  logic            has_eff;
  logic [SeqW-1:0] last_eff;
  logic [SeqW-1:0] last_inc;
  logic            gap_here;

  assign match_d    = ctrl_i.match_en ? (valid_q && (addr_q == req_i.mac)) : match_q;
  assign claim_here = !any_hit_i && !valid_q && !link_i.free_seen;
  assign sel_here   = match_q || claim_here;

  // A freshly claimed entry holds no sequence.
  assign has_eff  = match_q && has_q;
  assign last_eff = match_q ? last_q : '0;
  assign last_inc = last_eff + SeqW'(1);
  assign gap_here = req_i.track && has_eff && (req_i.seq != last_inc);

  always_comb begin
    valid_d = valid_q;
    has_d   = has_q;
    last_d  = last_q;
    if (ctrl_i.upd_en && sel_here) begin
      valid_d = 1'b1;
      has_d   = has_eff;
      last_d  = last_eff;
      if (req_i.track) begin
        has_d  = 1'b1;
        last_d = req_i.seq;
      end
    end
  end

  always_comb begin
    link_o.hit_seen  = link_i.hit_seen || match_q;
    link_o.free_seen = link_i.free_seen || !valid_q;
    link_o.sel       = link_i.sel || sel_here;
    link_o.idx       = sel_here ? cell_id_i : link_i.idx;
    link_o.gap       = sel_here ? gap_here : link_i.gap;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      has_q   <= 1'b0;
      last_q  <= '0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      has_q   <= has_d;
      last_q  <= last_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.upd_en && claim_here) begin
      addr_q <= req_i.mac;
    end
  end

endmodule
`default_nettype wire

[rtl/source_sequence_gap_table.sv]
// Top level of the source sequence gap table: sequencer, request register, cells, output register.
//
//  channel | signals                                            | direction
//  --------+----------------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, source_mac_i,              | to block
//          | sequence_number_i, track_sequence_i                |
//  out     | out_valid_o, out_ready_i, table_full_o,            | from block
//          | peer_index_o, seq_break_o                          |
//
// Each transaction passes from acceptance to a free input through these states:
// IDLE captures it, MATCH has every cell compare the address, and UPDATE lets
// the hit and free-entry chains ripple along the cells and writes the chosen
// entry.
// Reset empties the table at once; no clearing pass is needed.
// A transaction taken while a result waits at the output holds in UPDATE.
`default_nettype none
module source_sequence_gap_table (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [ssgt_pkg::MacW-1:0]      source_mac_i,
  input  wire logic [ssgt_pkg::SeqW-1:0]      sequence_number_i,
  input  wire logic                           track_sequence_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                table_full_o,
  output logic [ssgt_pkg::PeerIdxW-1:0]       peer_index_o,
  output logic                                seq_break_o
);
  import ssgt_pkg::*;

  state_e     state_q, state_d;
  req_t       req_q;
  cell_ctrl_t ctrl;
  logic       in_fire;
  logic       slot_free;

  // Chain of links; link[0] enters cell 0, link[PeerCount] leaves the last cell.
  link_t link [PeerCount+1];
  logic  any_hit;

  logic                     out_valid_q, out_valid_d;
  logic                     full_q;
  logic [PeerIdxW-1:0]      idx_q;
  logic                     gap_q;
  logic [IdxW+PeerIdxW-1:0] idx_ext;

  assign in_fire   = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_MATCH;
      ST_MATCH:  state_d = ST_UPDATE;
      ST_UPDATE: if (slot_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready_o    = 1'b0;
    ctrl.match_en = 1'b0;
    ctrl.upd_en   = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_ready_o    = 1'b1;
      ST_MATCH:  ctrl.match_en = 1'b1;
      ST_UPDATE: ctrl.upd_en   = slot_free;
      default:   in_ready_o    = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q.mac   <= source_mac_i;
      req_q.seq   <= sequence_number_i;
      req_q.track <= track_sequence_i;
    end
  end

  // Cell row
  assign link[0] = '0;
  // Hit field of the chain never depends on any_hit, so no loop forms.
  assign any_hit = link[PeerCount].hit_seen;

  for (genvar g = 0; g < PeerCount; g++) begin : g_cell
    ssgt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .req_i     (req_q),
      .cell_id_i (IdxW'(g)),
      .any_hit_i (any_hit),
      .link_i    (link[g]),
      .link_o    (link[g+1])
    );
  end

  // Output register; index carries the low bits of the entry number
  assign idx_ext     = {{PeerIdxW{1'b0}}, link[PeerCount].idx};
  assign out_valid_d = ctrl.upd_en ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.upd_en) begin
      full_q <= !link[PeerCount].sel;
      idx_q  <= link[PeerCount].sel ? idx_ext[PeerIdxW-1:0] : '0;
      gap_q  <= link[PeerCount].sel && link[PeerCount].gap;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign table_full_o = full_q;
  assign peer_index_o = idx_q;
  assign seq_break_o  = gap_q;

endmodule
`default_nettype wire

[test/gap_table_checker.sv]
// Checker for the source sequence gap table: watches both channels, predicts and compares.
`timescale 1ns / 100ps
module gap_table_checker
  import ssgt_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_ready_i,
  input  wire logic [MacW-1:0]     source_mac_i,
  input  wire logic [SeqW-1:0]     sequence_number_i,
  input  wire logic                track_sequence_i,
  input  wire logic                out_valid_i,
  input  wire logic                out_ready_i,
  input  wire logic                table_full_i,
  input  wire logic [PeerIdxW-1:0] peer_index_i,
  input  wire logic                seq_break_i,
  output int unsigned              mismatches_o,
  output int unsigned              pending_o,
  output int unsigned              results_o,
  output int unsigned              full_results_o,
  output int unsigned              gap_results_o
);

  typedef struct packed {
    logic                full;
    logic [PeerIdxW-1:0] idx;
    logic                gap;
  } verdict_t;

  // shadow copy of the peer table
  logic            peer_known    [PeerCount];
  logic [MacW-1:0] peer_mac      [PeerCount];
  logic            peer_has_seq  [PeerCount];
  logic [SeqW-1:0] peer_last_seq [PeerCount];

  verdict_t expected_verdicts[$];
  verdict_t want;

  initial begin
    mismatches_o   = 0;
    pending_o      = 0;
    results_o      = 0;
    full_results_o = 0;
    gap_results_o  = 0;
  end

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] wanted);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, field, got, wanted);
    mismatches_o++;
  endtask

  // Look the source up, claim the lowest free entry on a miss, then check continuity.
  function automatic verdict_t track_source(input logic [MacW-1:0] mac,
                                            input logic [SeqW-1:0] seq,
                                            input logic            track);
    verdict_t v;
    int       hit;
    v   = '0;
    hit = -1;
    for (int i = 0; i < PeerCount; i++)
      if (hit < 0 && peer_known[i] && peer_mac[i] == mac) hit = i;
    if (hit < 0) begin
      for (int i = 0; i < PeerCount; i++)
        if (hit < 0 && !peer_known[i]) hit = i;
      if (hit < 0) begin
        v.full = 1'b1;
        return v;
      end
      peer_known[hit]    = 1'b1;
      peer_mac[hit]      = mac;
      peer_has_seq[hit]  = 1'b0;
      peer_last_seq[hit] = '0;
    end
    if (track) begin
      v.gap = peer_has_seq[hit] && (seq != peer_last_seq[hit] + 1'b1);
      peer_last_seq[hit] = seq;
      peer_has_seq[hit]  = 1'b1;
    end
    v.idx = PeerIdxW'(hit);
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PeerCount; i++) begin
        peer_known[i]    = 1'b0;
        peer_mac[i]      = '0;
        peer_has_seq[i]  = 1'b0;
        peer_last_seq[i] = '0;
      end
      expected_verdicts.delete();
      pending_o <= 0;
    end else begin
      // results first: none can stem from a transaction taken at this same edge
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (table_full_i === 1'b1) full_results_o++;
        if (seq_break_i === 1'b1) gap_results_o++;
        if (expected_verdicts.size() == 0) begin
          report_mismatch("result with nothing expected", 64'd0, 64'd0);
        end else begin
          want = expected_verdicts.pop_front();
          if (table_full_i !== want.full)
            report_mismatch("table_full", 64'(table_full_i), 64'(want.full));
          if (peer_index_i !== want.idx)
            report_mismatch("peer_index", 64'(peer_index_i), 64'(want.idx));
          if (seq_break_i !== want.gap)
            report_mismatch("seq_break", 64'(seq_break_i), 64'(want.gap));
        end
      end
      if (in_valid_i && in_ready_i)
        expected_verdicts.push_back(track_source(source_mac_i, sequence_number_i,
                                                 track_sequence_i));
      pending_o <= expected_verdicts.size();
    end
  end

endmodule

[test/tb.sv]
// Testbench top for the source sequence gap table: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb
  import ssgt_pkg::*;
();

  localparam int unsigned CycleLimit     = 200_000;
  localparam int unsigned RandomPerPhase = 127;
  localparam int unsigned StallCycles    = 80;
  localparam int unsigned SettleCycles   = 16;

  logic                clk_i             = 1'b0;
  logic                rst_ni            = 1'b0;
  logic                in_valid_i        = 1'b0;
  logic                in_ready_o;
  logic [MacW-1:0]     source_mac_i      = '0;
  logic [SeqW-1:0]     sequence_number_i = '0;
  logic                track_sequence_i  = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i       = 1'b0;
  logic                table_full_o;
  logic [PeerIdxW-1:0] peer_index_o;
  logic                seq_break_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned results;
  int unsigned full_results;
  int unsigned gap_results;

  // idling odds, in percent of cycles
  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_idle_pct = 0;

  // receiver hold-off: requested by the stimulus, timed by the receiver process
  logic        stall_request = 1'b0;
  logic        stall_taken   = 1'b0;
  int unsigned stall_left    = 0;

  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;

  // Stimulus-side view of the peers: addresses in use and the last tracked number
  // sent to each, so that most sequences can be made contiguous.
  logic [MacW-1:0] peer_mac      [PeerCount];
  logic [SeqW-1:0] peer_last_seq [PeerCount];

  always #5 clk_i = ~clk_i;

  source_sequence_gap_table i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .source_mac_i      (source_mac_i),
    .sequence_number_i (sequence_number_i),
    .track_sequence_i  (track_sequence_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .table_full_o      (table_full_o),
    .peer_index_o      (peer_index_o),
    .seq_break_o       (seq_break_o)
  );

  gap_table_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .source_mac_i      (source_mac_i),
    .sequence_number_i (sequence_number_i),
    .track_sequence_i  (track_sequence_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .table_full_i      (table_full_o),
    .peer_index_i      (peer_index_o),
    .seq_break_i       (seq_break_o),
    .mismatches_o      (mismatches),
    .pending_o         (pending),
    .results_o         (results),
    .full_results_o    (full_results),
    .gap_results_o     (gap_results)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off once requested.
  // The hold-off lets the block fill up so that it must stall its input.
  always @(posedge clk_i) begin
    if (stall_request && !stall_taken) begin
      stall_taken = 1'b1;
      stall_left  = StallCycles;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  function automatic logic [MacW-1:0] fresh_mac();
    return MacW'({$urandom, $urandom});
  endfunction

  // Offer one transaction and hold it until taken. Valid is only lowered for an
  // idle gap, never at the end, so back-to-back transactions keep valid high.
  task automatic send_item(input logic [MacW-1:0] mac, input logic [SeqW-1:0] seq,
                           input logic track);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid_i        <= 1'b1;
    source_mac_i      <= mac;
    sequence_number_i <= seq;
    track_sequence_i  <= track;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic send_to_peer(input int k, input logic [SeqW-1:0] seq, input logic track);
    if (track) peer_last_seq[k] = seq;
    send_item(peer_mac[k], seq, track);
  endtask

  // Sender pause: nothing offered until every expected result is out.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Mostly well-formed runs of contiguous numbers per peer, with gaps, repeats,
  // runs across the wrap, untracked packets and unknown sources mixed in.
  task automatic random_burst(input int unsigned count);
    int unsigned r;
    int          k;
    for (int unsigned n = 0; n < count; n++) begin
      r = $urandom_range(99);
      k = $urandom_range(PeerCount - 1);
      if (r < 60)
        send_to_peer(k, peer_last_seq[k] + 1'b1, 1'b1);
      else if (r < 70)
        send_to_peer(k, $urandom, 1'b1);
      else if (r < 75)
        send_to_peer(k, '1 - SeqW'($urandom_range(2)), 1'b1);
      else if (r < 85)
        send_to_peer(k, $urandom, 1'b0);
      else if (r < 95)
        send_item(fresh_mac(), $urandom, 1'($urandom_range(1)));
      else
        send_to_peer(k, peer_last_seq[k], 1'b1);
    end
  endtask

  initial begin
    peer_mac[0] = '0;
    peer_mac[1] = '1;
    for (int k = 2; k < PeerCount; k++) begin
      peer_mac[k]      = fresh_mac();
      peer_mac[k][2:0] = 3'(k);
    end
    for (int k = 0; k < PeerCount; k++) peer_last_seq[k] = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // regime one: sender idles now and then, receiver mostly stalls
    sender_idle_pct   = 26;
    receiver_idle_pct = 87;

    // Directed part. Lowest address, first tracked packet, then contiguous,
    // a gap, an untracked packet that leaves the stored number alone.
    send_to_peer(0, 32'd0, 1'b1);
    send_to_peer(0, 32'd1, 1'b1);
    send_to_peer(0, 32'd5, 1'b1);
    send_to_peer(0, 32'd9, 1'b0);
    send_to_peer(0, 32'd6, 1'b1);
    // highest address; sequence wraps from all ones to zero, then repeats
    send_to_peer(1, '1, 1'b1);
    send_to_peer(1, 32'd0, 1'b1);
    send_to_peer(1, 32'd0, 1'b1);
    // claimed by an untracked packet: its first tracked one must not gap
    send_to_peer(2, $urandom, 1'b0);
    send_to_peer(2, 32'd123, 1'b1);
    send_to_peer(2, 32'd124, 1'b1);
    // fill the remaining entries in order
    for (int k = 3; k < PeerCount; k++) send_to_peer(k, $urandom, 1'b1);
    // table now full: unknown sources are refused, known ones still served
    send_item(fresh_mac(), $urandom, 1'b1);
    send_item(fresh_mac(), 32'd0, 1'b0);
    send_to_peer(0, 32'd7, 1'b1);
    send_to_peer(1, 32'd1, 1'b1);

    random_burst(RandomPerPhase);
    drain();

    // regime two: the other way round
    sender_idle_pct   = 87;
    receiver_idle_pct = 26;
    random_burst(RandomPerPhase);
    drain();

    // regime three: no idling, one long receiver hold-off at its start
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    stall_request <= 1'b1;
    random_burst(RandomPerPhase);
    drain();

    // let any stray result show before the verdict
    repeat (SettleCycles) @(posedge clk_i);

    $display("run covered %0d transactions in, %0d results out, %0d refused as full, %0d gaps",
             items_sent, results, full_results, gap_results);
    $display("three idling regimes, one receiver hold-off of %0d cycles, %0d cycles in all",
             StallCycles, cycle_count);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
